[rtl/i2cebm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cebm_pkg
// shared types and constants of the eeprom byte master
// ----------------------------------------------------------------------------
package i2cebm_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
    localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd200;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST1     = 5'd1,
        PH_ST2     = 5'd2,
        PH_ST3     = 5'd3,
        PH_ST4     = 5'd4,
        PH_WB_D    = 5'd5,
        PH_WB_H    = 5'd6,
        PH_WB_L    = 5'd7,
        PH_AK_REL  = 5'd8,
        PH_AK_CLK  = 5'd9,
        PH_AK_POLL = 5'd10,
        PH_RD_REL  = 5'd11,
        PH_RD_H    = 5'd12,
        PH_RD_S    = 5'd13,
        PH_RD_L    = 5'd14,
        PH_SP1     = 5'd15,
        PH_SP2     = 5'd16,
        PH_SP3     = 5'd17
    } phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] word_address;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_missed;
    } result_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] ack_poll_limit;
    } cfg_t;

endpackage

[rtl/i2c_eeprom_byte_master_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master_core
// pin-level i2c master for eeprom byte write and random byte read
// ----------------------------------------------------------------------------
// Each input transaction is one bit-phase tick and yields exactly one result
// transaction holding the pin levels and status after that tick. The block
// takes one transaction per clock while the result side is not stalled; a result
// is loaded into the result register after its input has passed the input register,
// with the combinational sequencer step between the two registers. A full result register
// that is being taken does not stall the input side.
module i2c_eeprom_byte_master_core
    import i2cebm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] word_address,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_byte,
    output logic       ack_missed
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t step_result;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RST;
            cfg_reg.ack_poll_limit <= ACK_POLL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                CFG_ACK_POLL_LIMIT: cfg_reg.ack_poll_limit <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{action: action, word_address: word_address,
                          write_data: write_data, sda_in: sda_in};
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    i2cebm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    assign out_valid  = out_valid_reg;
    assign scl_level  = result_reg.scl_level;
    assign sda_level  = result_reg.sda_level;
    assign sda_drive  = result_reg.sda_drive;
    assign busy_res   = result_reg.busy_res;
    assign done_res   = result_reg.done_res;
    assign read_byte  = result_reg.read_byte;
    assign ack_missed = result_reg.ack_missed;

    // stop completes with both bus lines high and driven, and the sequence finished
    a_done_bus_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.done_res |->
            !result_reg.busy_res && result_reg.scl_level && result_reg.sda_level
            && result_reg.sda_drive)
        else $error("done without stop condition on the bus");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("sequencer step without a result");

    a_no_step_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !advance)
        else $error("sequencer stepped without an item");

endmodule

[rtl/i2cebm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cebm_seq
// bit-phase sequencer: one pin action per tick, state held here
// ----------------------------------------------------------------------------
module i2cebm_seq
    import i2cebm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [2:0] byte_index_reg, byte_index_next;
    logic [7:0] ack_wait_reg, ack_wait_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] received_reg, received_next;
    logic       ack_error_reg, ack_error_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       sda_dir_reg, sda_dir_next;
    logic [7:0] lat_word_reg, lat_word_next;
    logic [7:0] lat_data_reg, lat_data_next;

    function automatic logic [7:0] byte_sel(
        input logic [2:0] idx,
        input logic       rd,
        input logic [6:0] dev,
        input logic [7:0] word,
        input logic [7:0] data
    );
        logic [7:0] b;
        b = {dev, 1'b0};
        if (idx == 3'd1)
        begin
            b = word;
        end
        else if (idx != 3'd0)
        begin
            b = rd ? {dev, 1'b1} : data;
        end
        return b;
    endfunction

    always_comb
    begin
        logic       done;
        logic [3:0] bc_inc;
        logic [8:0] cnt;
        logic [2:0] bi_inc;
        logic       do_after;

        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_byte_next = shift_byte_reg;
        byte_index_next = byte_index_reg;
        ack_wait_next   = ack_wait_reg;
        is_read_next    = is_read_reg;
        received_next   = received_reg;
        ack_error_next  = ack_error_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_dir_next    = sda_dir_reg;
        lat_word_next   = lat_word_reg;
        lat_data_next   = lat_data_reg;
        done            = 1'b0;
        bc_inc          = bit_count_reg + 4'd1;
        cnt             = {1'b0, ack_wait_reg} + 9'd1;
        do_after        = 1'b0;

        // request taken only when idle
        if (phase_reg == PH_IDLE && (item.action == ACT_WRITE || item.action == ACT_READ))
        begin
            is_read_next    = (item.action == ACT_READ);
            lat_word_next   = item.word_address;
            lat_data_next   = item.write_data;
            ack_error_next  = 1'b0;
            byte_index_next = 3'd0;
            bit_count_next  = 4'd0;
            ack_wait_next   = 8'd0;
            phase_next      = PH_ST1;
        end

        bi_inc = byte_index_next + 3'd1;

        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_ST1:
            begin
                sda_dir_next = 1'b1;
                sda_next     = 1'b1;
                phase_next   = PH_ST2;
            end
            PH_ST2:
            begin
                scl_next   = 1'b1;
                phase_next = PH_ST3;
            end
            PH_ST3:
            begin
                sda_next   = 1'b0;
                phase_next = PH_ST4;
            end
            PH_ST4:
            begin
                scl_next        = 1'b0;
                shift_byte_next = byte_sel(byte_index_next, is_read_next,
                                           cfg.device_address, lat_word_next,
                                           lat_data_next);
                bit_count_next  = 4'd0;
                phase_next      = PH_WB_D;
            end
            PH_WB_D:
            begin
                sda_dir_next    = 1'b1;
                sda_next        = shift_byte_reg[7];
                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                phase_next      = PH_WB_H;
            end
            PH_WB_H:
            begin
                scl_next   = 1'b1;
                phase_next = PH_WB_L;
            end
            PH_WB_L:
            begin
                scl_next       = 1'b0;
                bit_count_next = bc_inc;
                phase_next     = bc_inc[3] ? PH_AK_REL : PH_WB_D;
            end
            PH_AK_REL:
            begin
                sda_next   = 1'b1;
                phase_next = PH_AK_CLK;
            end
            PH_AK_CLK:
            begin
                scl_next      = 1'b1;
                sda_dir_next  = 1'b0;
                ack_wait_next = 8'd0;
                phase_next    = PH_AK_POLL;
            end
            PH_AK_POLL:
            begin
                if (!item.sda_in)
                begin
                    scl_next = 1'b0;
                    do_after = 1'b1;
                end
                else if (cnt > {1'b0, cfg.ack_poll_limit})
                begin
                    ack_error_next = 1'b1;
                    scl_next       = 1'b0;
                    do_after       = 1'b1;
                end
                else
                begin
                    ack_wait_next = cnt[7:0];
                end
            end
            PH_RD_REL:
            begin
                sda_next        = 1'b1;
                sda_dir_next    = 1'b0;
                bit_count_next  = 4'd0;
                shift_byte_next = 8'd0;
                phase_next      = PH_RD_H;
            end
            PH_RD_H:
            begin
                scl_next   = 1'b1;
                phase_next = PH_RD_S;
            end
            PH_RD_S:
            begin
                shift_byte_next = {shift_byte_reg[6:0], item.sda_in};
                phase_next      = PH_RD_L;
            end
            PH_RD_L:
            begin
                scl_next       = 1'b0;
                bit_count_next = bc_inc;
                if (bc_inc[3])
                begin
                    received_next = shift_byte_reg;
                    phase_next    = PH_SP1;
                end
                else
                begin
                    phase_next = PH_RD_H;
                end
            end
            PH_SP1:
            begin
                sda_dir_next = 1'b1;
                sda_next     = 1'b0;
                phase_next   = PH_SP2;
            end
            PH_SP2:
            begin
                scl_next   = 1'b1;
                phase_next = PH_SP3;
            end
            PH_SP3:
            begin
                sda_next   = 1'b1;
                done       = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // next byte after an acknowledge or a poll timeout
        if (do_after)
        begin
            byte_index_next = bi_inc;
            if (!is_read_next)
            begin
                if (bi_inc < 3'd3)
                begin
                    shift_byte_next = byte_sel(bi_inc, is_read_next, cfg.device_address,
                                               lat_word_next, lat_data_next);
                    bit_count_next  = 4'd0;
                    phase_next      = PH_WB_D;
                end
                else
                begin
                    phase_next = PH_SP1;
                end
            end
            else if (bi_inc == 3'd2)
            begin
                phase_next = PH_ST1;
            end
            else if (bi_inc >= 3'd3)
            begin
                phase_next = PH_RD_REL;
            end
            else
            begin
                shift_byte_next = byte_sel(bi_inc, is_read_next, cfg.device_address,
                                           lat_word_next, lat_data_next);
                bit_count_next  = 4'd0;
                phase_next      = PH_WB_D;
            end
        end

        result.scl_level  = scl_next;
        result.sda_level  = sda_next;
        result.sda_drive  = sda_dir_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.read_byte  = received_next;
        result.ack_missed = ack_error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_byte_reg <= 8'd0;
            byte_index_reg <= 3'd0;
            ack_wait_reg   <= 8'd0;
            is_read_reg    <= 1'b0;
            received_reg   <= 8'd0;
            ack_error_reg  <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_dir_reg    <= 1'b1;
            lat_word_reg   <= 8'd0;
            lat_data_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_byte_reg <= shift_byte_next;
            byte_index_reg <= byte_index_next;
            ack_wait_reg   <= ack_wait_next;
            is_read_reg    <= is_read_next;
            received_reg   <= received_next;
            ack_error_reg  <= ack_error_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            sda_dir_reg    <= sda_dir_next;
            lat_word_reg   <= lat_word_next;
            lat_data_reg   <= lat_data_next;
        end
    end

endmodule

[dv/i2c_eeprom_byte_master_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master_core_test
// Self-checking bench for the pin-level eeprom byte master. Every accepted
// input tick is run through a bit-accurate model of the bus sequencer, and
// every result transaction is compared field by field with the oldest
// prediction. A second copy of the same model shapes the stimulus, so that
// acknowledge polls and read bits land on the phases where they matter.
// Directed corners come first, then random transfers under several register
// settings, with random idle and stall cycles on both handshakes.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master_core_test;
    import i2cebm_pkg::*;

    // unused action code, behaves as a tick
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        phase_t     ph;
        logic [3:0] nbits;
        logic [7:0] shreg;
        logic [2:0] byte_no;
        logic [7:0] polls;
        logic       rd_mode;
        logic [7:0] rx_byte;
        logic       ack_err;
        logic       scl;
        logic       sda;
        logic       drv;
        logic [7:0] word_lat;
        logic [7:0] data_lat;
    } bus_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_DEVICE_ADDRESS;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] action = ACT_TICK;
    logic [7:0] word_address = 8'd0;
    logic [7:0] write_data = 8'd0;
    logic       sda_in = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missed;

    cfg_t       cfg_model;
    bus_state_t chk_state;
    bus_state_t gen_state;
    item_t      pending_items[$];
    result_t    expected_results[$];

    int gap_left = 0;
    int stall_left = 0;
    int send_burst = 0;
    int recv_burst = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int write_starts = 0;
    int read_starts = 0;
    int stop_count = 0;
    int nak_count = 0;

    i2c_eeprom_byte_master_core dut (.*);

    initial begin : clock_gen
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        #5_000_000;
        $display("i2c_eeprom_byte_master_core: mismatch");
        $finish;
    end

    function automatic bus_state_t bus_reset_state();
        bus_state_t s;
        s = '0;
        s.ph = PH_IDLE;
        s.scl = 1'b1;
        s.sda = 1'b1;
        s.drv = 1'b1;
        return s;
    endfunction

    function automatic logic [7:0] byte_on_wire(bus_state_t s, cfg_t c);
        logic [7:0] dev;
        dev = {c.device_address, 1'b0};
        if (s.byte_no == 3'd0)
            return dev;
        if (s.byte_no == 3'd1)
            return s.word_lat;
        if (s.rd_mode)
            return dev | 8'd1;
        return s.data_lat;
    endfunction

    function automatic bus_state_t next_after_ack(bus_state_t s, cfg_t c);
        bus_state_t n;
        n = s;
        n.byte_no = s.byte_no + 3'd1;
        if (!n.rd_mode) begin
            if (n.byte_no < 3'd3)
            begin
                n.shreg = byte_on_wire(n, c);
                n.nbits = 4'd0;
                n.ph = PH_WB_D;
            end
            else
                n.ph = PH_SP1;
        end
        else if (n.byte_no == 3'd2)
            n.ph = PH_ST1;
        else if (n.byte_no >= 3'd3)
            n.ph = PH_RD_REL;
        else
        begin
            n.shreg = byte_on_wire(n, c);
            n.nbits = 4'd0;
            n.ph = PH_WB_D;
        end
        return n;
    endfunction

    // one bit-phase tick of the sequencer
    function automatic bus_state_t bus_step(bus_state_t s, cfg_t c, item_t it,
                                            output result_t r);
        bus_state_t n;
        logic       done;
        logic [8:0] cnt;
        n = s;
        done = 1'b0;
        if (n.ph == PH_IDLE && (it.action == ACT_WRITE || it.action == ACT_READ))
        begin
            n.rd_mode = (it.action == ACT_READ);
            n.word_lat = it.word_address;
            n.data_lat = it.write_data;
            n.ack_err = 1'b0;
            n.byte_no = 3'd0;
            n.nbits = 4'd0;
            n.polls = 8'd0;
            n.ph = PH_ST1;
        end
        case (n.ph)
            PH_IDLE:
                done = 1'b0;
            PH_ST1:
            begin
                n.drv = 1'b1;
                n.sda = 1'b1;
                n.ph = PH_ST2;
            end
            PH_ST2:
            begin
                n.scl = 1'b1;
                n.ph = PH_ST3;
            end
            PH_ST3:
            begin
                n.sda = 1'b0;
                n.ph = PH_ST4;
            end
            PH_ST4:
            begin
                n.scl = 1'b0;
                n.shreg = byte_on_wire(n, c);
                n.nbits = 4'd0;
                n.ph = PH_WB_D;
            end
            PH_WB_D:
            begin
                n.drv = 1'b1;
                n.sda = n.shreg[7];
                n.shreg = {n.shreg[6:0], 1'b0};
                n.ph = PH_WB_H;
            end
            PH_WB_H:
            begin
                n.scl = 1'b1;
                n.ph = PH_WB_L;
            end
            PH_WB_L:
            begin
                n.scl = 1'b0;
                n.nbits = n.nbits + 4'd1;
                if (n.nbits >= 4'd8)
                    n.ph = PH_AK_REL;
                else
                    n.ph = PH_WB_D;
            end
            PH_AK_REL:
            begin
                n.sda = 1'b1;
                n.ph = PH_AK_CLK;
            end
            PH_AK_CLK:
            begin
                n.scl = 1'b1;
                n.drv = 1'b0;
                n.polls = 8'd0;
                n.ph = PH_AK_POLL;
            end
            PH_AK_POLL:
            begin
                cnt = {1'b0, n.polls} + 9'd1;
                if (!it.sda_in)
                begin
                    n.scl = 1'b0;
                    n = next_after_ack(n, c);
                end
                else if (cnt > {1'b0, c.ack_poll_limit})
                begin
                    n.ack_err = 1'b1;
                    n.scl = 1'b0;
                    n = next_after_ack(n, c);
                end
                else
                    n.polls = cnt[7:0];
            end
            PH_RD_REL:
            begin
                n.sda = 1'b1;
                n.drv = 1'b0;
                n.nbits = 4'd0;
                n.shreg = 8'd0;
                n.ph = PH_RD_H;
            end
            PH_RD_H:
            begin
                n.scl = 1'b1;
                n.ph = PH_RD_S;
            end
            PH_RD_S:
            begin
                n.shreg = {n.shreg[6:0], it.sda_in};
                n.ph = PH_RD_L;
            end
            PH_RD_L:
            begin
                n.scl = 1'b0;
                n.nbits = n.nbits + 4'd1;
                if (n.nbits >= 4'd8)
                begin
                    n.rx_byte = n.shreg;
                    n.ph = PH_SP1;
                end
                else
                    n.ph = PH_RD_H;
            end
            PH_SP1:
            begin
                n.drv = 1'b1;
                n.sda = 1'b0;
                n.ph = PH_SP2;
            end
            PH_SP2:
            begin
                n.scl = 1'b1;
                n.ph = PH_SP3;
            end
            PH_SP3:
            begin
                n.sda = 1'b1;
                done = 1'b1;
                n.ph = PH_IDLE;
            end
            default:
                n.ph = PH_IDLE;
        endcase
        r.scl_level = n.scl;
        r.sda_level = n.sda;
        r.sda_drive = n.drv;
        r.busy_res = (n.ph != PH_IDLE);
        r.done_res = done;
        r.read_byte = n.rx_byte;
        r.ack_missed = n.ack_err;
        return n;
    endfunction

    // mostly short waits, sometimes long runs with none at all
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            burst = $urandom_range(16, 64);
            return 0;
        end
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // sda level for the next tick, given the phase it will be seen in
    function automatic logic pick_sda(int hi_pct);
        if (gen_state.ph == PH_AK_POLL)
            return ($urandom_range(0, 99) < hi_pct);
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic push_item(input item_t it);
        result_t scratch;
        pending_items.push_back(it);
        gen_state = bus_step(gen_state, cfg_model, it, scratch);
    endtask

    task automatic push_fields(input logic [1:0] act, input logic [7:0] wa,
                               input logic [7:0] wd, input logic sda);
        item_t it;
        it = {act, wa, wd, sda};
        push_item(it);
    endtask

    task automatic fill_to_idle(input int hi_pct);
        item_t it;
        while (gen_state.ph != PH_IDLE)
        begin
            it.action = ACT_TICK;
            it.word_address = 8'($urandom_range(0, 255));
            it.write_data = 8'($urandom_range(0, 255));
            it.sda_in = pick_sda(hi_pct);
            push_item(it);
        end
    endtask

    task automatic gen_random(input int count, input int hi_pct);
        item_t it;
        int    k;
        int    seq_hi;
        seq_hi = hi_pct;
        for (k = 0; k < count; k++)
        begin
            it.word_address = 8'($urandom_range(0, 255));
            it.write_data = 8'($urandom_range(0, 255));
            if (gen_state.ph == PH_IDLE)
            begin
                case ($urandom_range(0, 9))
                    0: it.action = ACT_TICK;
                    1: it.action = ACT_SPARE;
                    default: it.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
                endcase
                // now and then a device that never acknowledges
                if (it.action == ACT_WRITE || it.action == ACT_READ)
                    seq_hi = ($urandom_range(0, 9) == 0) ? 100 : hi_pct;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0: it.action = ACT_WRITE;
                    1: it.action = ACT_READ;
                    2: it.action = ACT_SPARE;
                    default: it.action = ACT_TICK;
                endcase
            end
            it.sda_in = pick_sda(seq_hi);
            push_item(it);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS)
            cfg_model.device_address = value[6:0];
        else
            cfg_model.ack_poll_limit = value;
        @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input int want_v, input int seen_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("result %0d: %s expected %0h got %0h", results_seen, what,
                     want_v, seen_v);
    endtask

    always @(posedge clk)
    begin : driver
        item_t   cur;
        item_t   nxt;
        result_t pred;
        logic    hold;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            hold = in_valid;
            if (in_valid && in_ready)
            begin
                cur = {action, word_address, write_data, sda_in};
                if (chk_state.ph == PH_IDLE)
                begin
                    if (action == ACT_WRITE)
                        write_starts++;
                    if (action == ACT_READ)
                        read_starts++;
                end
                chk_state = bus_step(chk_state, cfg_model, cur, pred);
                expected_results.push_back(pred);
                hold = 1'b0;
            end
            if (!hold)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    action <= nxt.action;
                    word_address <= nxt.word_address;
                    write_data <= nxt.write_data;
                    sda_in <= nxt.sda_in;
                    hold = 1'b1;
                    gap_left <= draw_wait(send_burst);
                end
            end
            in_valid <= hold;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t seen;
        result_t want;
        logic    rdy;
        int      stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            rdy = out_ready;
            if (out_valid && out_ready)
            begin
                seen = {scl_level, sda_level, sda_drive, busy_res, done_res, read_byte,
                        ack_missed};
                results_seen++;
                if (expected_results.size() == 0)
                    note_mismatch("unexpected result", 0, seen);
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.scl_level !== want.scl_level)
                        note_mismatch("scl_level", want.scl_level, seen.scl_level);
                    if (seen.sda_level !== want.sda_level)
                        note_mismatch("sda_level", want.sda_level, seen.sda_level);
                    if (seen.sda_drive !== want.sda_drive)
                        note_mismatch("sda_drive", want.sda_drive, seen.sda_drive);
                    if (seen.busy_res !== want.busy_res)
                        note_mismatch("busy_res", want.busy_res, seen.busy_res);
                    if (seen.done_res !== want.done_res)
                        note_mismatch("done_res", want.done_res, seen.done_res);
                    if (seen.read_byte !== want.read_byte)
                        note_mismatch("read_byte", want.read_byte, seen.read_byte);
                    if (seen.ack_missed !== want.ack_missed)
                        note_mismatch("ack_missed", want.ack_missed, seen.ack_missed);
                    if (want.done_res)
                    begin
                        stop_count++;
                        if (want.ack_missed)
                            nak_count++;
                    end
                end
                stall = draw_wait(recv_burst);
                if (stall > 0)
                begin
                    rdy = 1'b0;
                    stall_left <= stall;
                end
            end
            else if (!out_ready)
            begin
                if (stall_left > 1)
                    stall_left <= stall_left - 1;
                else
                    rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    initial
    begin : stimulus
        int         phase_no;
        int         hi_pct;
        logic [7:0] addr_val;
        logic [7:0] limit_val;
        cfg_model.device_address = DEVICE_ADDRESS_RST;
        cfg_model.ack_poll_limit = ACK_POLL_LIMIT_RST;
        chk_state = bus_reset_state();
        gen_state = bus_reset_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks, spare action, write at the field extremes, request while busy
        push_fields(ACT_TICK, 8'h00, 8'h00, 1'b0);
        push_fields(ACT_SPARE, 8'hFF, 8'hFF, 1'b1);
        push_fields(ACT_WRITE, 8'hFF, 8'h00, 1'b1);
        push_fields(ACT_READ, 8'h00, 8'hFF, 1'b0);
        fill_to_idle(0);
        push_fields(ACT_READ, 8'h00, 8'hFF, 1'b0);
        fill_to_idle(20);
        wait_drained();

        // zero poll limit: first high poll already counts as missed
        write_reg(CFG_ACK_POLL_LIMIT, 8'h00);
        write_reg(CFG_DEVICE_ADDRESS, 8'hFF);
        push_fields(ACT_WRITE, 8'h5A, 8'hA5, 1'b1);
        fill_to_idle(100);
        push_fields(ACT_READ, 8'hA5, 8'h5A, 1'b1);
        fill_to_idle(100);
        wait_drained();

        // longest poll limit with a silent device
        write_reg(CFG_ACK_POLL_LIMIT, 8'hFF);
        write_reg(CFG_DEVICE_ADDRESS, 8'h00);
        push_fields(ACT_WRITE, 8'h0F, 8'hF0, 1'b0);
        fill_to_idle(100);
        wait_drained();

        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            case (phase_no)
                0:
                begin
                    addr_val = 8'($urandom_range(0, 255));
                    limit_val = 8'($urandom_range(1, 4));
                    hi_pct = 50;
                end
                1:
                begin
                    addr_val = {1'b0, DEVICE_ADDRESS_RST};
                    limit_val = ACK_POLL_LIMIT_RST;
                    hi_pct = 30;
                end
                2:
                begin
                    addr_val = 8'h7F;
                    limit_val = 8'hFF;
                    hi_pct = 30;
                end
                3:
                begin
                    addr_val = 8'($urandom_range(0, 255));
                    limit_val = 8'($urandom_range(1, 255));
                    hi_pct = 40;
                end
                4:
                begin
                    addr_val = 8'h00;
                    limit_val = 8'h01;
                    hi_pct = 60;
                end
                default:
                begin
                    addr_val = 8'($urandom_range(0, 255));
                    limit_val = 8'h00;
                    hi_pct = 30;
                end
            endcase
            write_reg(CFG_DEVICE_ADDRESS, addr_val);
            write_reg(CFG_ACK_POLL_LIMIT, limit_val);
            gen_random(60, hi_pct);
            fill_to_idle(30);
            wait_drained();
        end

        repeat (10) @(negedge clk);
        $display("checked %0d result transactions: %0d writes and %0d reads started",
                 results_seen, write_starts, read_starts);
        $display("%0d stop conditions, %0d of them after a missed acknowledge",
                 stop_count, nak_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("i2c_eeprom_byte_master_core: match");
        else
            $display("i2c_eeprom_byte_master_core: mismatch");
        $finish;
    end

endmodule

[i2c_eeprom_byte_master_core.f]
rtl/i2cebm_pkg.sv
rtl/i2cebm_seq.sv
rtl/i2c_eeprom_byte_master_core.sv
dv/i2c_eeprom_byte_master_core_test.sv
